### rtl/core/llcd_pkg.sv
// Shared types, constants and small functions for the lidar leg cluster detector.
// Depends on nothing; every other file of the block but llcd_if imports it.
`timescale 1ns / 1ps
`default_nettype none
package llcd_pkg;

   // register map, word index
   localparam logic [2:0] REG_CLUSTER_RADIUS = 3'd0;
   localparam logic [2:0] REG_MIN_CURVE      = 3'd1;
   localparam logic [2:0] REG_LEG_LEN_MIN    = 3'd2;
   localparam logic [2:0] REG_LEG_LEN_MAX    = 3'd3;
   localparam logic [2:0] REG_MAX_TARGET     = 3'd4;
   localparam logic [2:0] REG_ANGLE_START    = 3'd5;
   localparam logic [2:0] REG_ANGLE_STEP     = 3'd6;
   localparam logic [2:0] REG_ANGLE_END      = 3'd7;

   localparam logic [15:0] RST_CLUSTER_RADIUS = 16'd500;
   localparam logic [15:0] RST_MIN_CURVE      = 16'd282;
   localparam logic [15:0] RST_LEG_LEN_MIN    = 16'd60;
   localparam logic [15:0] RST_LEG_LEN_MAX    = 16'd200;
   localparam logic [15:0] RST_MAX_TARGET     = 16'd5000;
   localparam logic [15:0] RST_ANGLE_START    = 16'h8000;
   localparam logic [15:0] RST_ANGLE_STEP     = 16'd64;
   localparam logic [15:0] RST_ANGLE_END      = 16'h7FFF;

   // report kinds
   localparam logic KIND_LEG    = 1'b0;
   localparam logic KIND_TARGET = 1'b1;

   // inverse CORDIC gain, Q16
   localparam logic [15:0] KINV_Q16 = 16'd39797;
   localparam int          MAX_ROT  = 24;

   typedef struct packed {
      logic [15:0] cluster_radius_mm;
      logic [15:0] min_curve_q8;
      logic [15:0] leg_len_min_mm;
      logic [15:0] leg_len_max_mm;
      logic [15:0] max_target_mm;
      logic [15:0] angle_start;
      logic [15:0] angle_step;
      logic [15:0] angle_end;
   } cfg_type;

   // one beat from the front end to the back end
   typedef struct packed {
      logic               pt;
      logic               eos;
      logic signed [16:0] x;
      logic signed [16:0] y;
   } pt_entry_type;

   // arctangent of 2^-i, angle units scaled by 256
   function automatic logic signed [24:0] atan_val(input logic [4:0] i);
      logic signed [24:0] v;
      unique case (i)
         5'd0:  v = 25'sd2097152;
         5'd1:  v = 25'sd1238021;
         5'd2:  v = 25'sd654136;
         5'd3:  v = 25'sd332050;
         5'd4:  v = 25'sd166669;
         5'd5:  v = 25'sd83416;
         5'd6:  v = 25'sd41718;
         5'd7:  v = 25'sd20860;
         5'd8:  v = 25'sd10430;
         5'd9:  v = 25'sd5215;
         5'd10: v = 25'sd2608;
         5'd11: v = 25'sd1304;
         5'd12: v = 25'sd652;
         5'd13: v = 25'sd326;
         5'd14: v = 25'sd163;
         5'd15: v = 25'sd81;
         5'd16: v = 25'sd41;
         5'd17: v = 25'sd20;
         5'd18: v = 25'sd10;
         5'd19: v = 25'sd5;
         5'd20: v = 25'sd3;
         5'd21: v = 25'sd1;
         5'd22: v = 25'sd1;
         default: v = 25'sd0;
      endcase
      return v;
   endfunction

   // saturate to the 17-bit position range
   function automatic logic signed [16:0] clamp_pos(input logic signed [39:0] v);
      logic signed [16:0] r;
      if (v < -40'sd65536)
         r = -17'sd65536;
      else if (v > 40'sd65535)
         r = 17'sd65535;
      else
         r = v[16:0];
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/core/llcd_if.sv
// Valid/ready channel interfaces for the sample input and the report output.
// Depend on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface llcd_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] range_mm;
   logic        end_of_scan;
   modport source (output valid, output range_mm, output end_of_scan, input ready);
   modport sink   (input valid, input range_mm, input end_of_scan, output ready);
endinterface

interface llcd_rsp_if;
   logic               valid;
   logic               ready;
   logic               report_kind;
   logic signed [16:0] pos_x_mm;
   logic signed [16:0] pos_y_mm;
   logic               target_updated;
   logic               last_of_run;
   modport source (output valid, output report_kind, output pos_x_mm, output pos_y_mm,
                   output target_updated, output last_of_run, input ready);
   modport sink   (input valid, input report_kind, input pos_x_mm, input pos_y_mm,
                   input target_updated, input last_of_run, output ready);
endinterface
`default_nettype wire

### rtl/core/llcd_front.sv
// Front end: beam angle tracking, end-angle cut and iterative CORDIC rotation.
// Depends on llcd_pkg and llcd_if.
`timescale 1ns / 1ps
`default_nettype none
module llcd_front #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   llcd_req_if.sink                   req,
   input  wire llcd_pkg::cfg_type     cfg,
   output llcd_pkg::pt_entry_type     push_entry,
   output logic                       push_valid,
   input  wire logic                  push_ready
);
   import llcd_pkg::*;

   localparam int STEPS = (CORDIC_STEPS < MAX_ROT) ? CORDIC_STEPS : MAX_ROT;

   typedef enum logic [1:0] {F_IDLE, F_ROT, F_PUSH} fstate_type;

   fstate_type         state_ff;
   logic               scan_active_ff;
   logic               past_end_ff;
   logic [15:0]        beam_ff;
   logic               pt_ff;
   logic               eos_ff;
   logic               flip_ff;
   logic [4:0]         iter_ff;
   logic signed [35:0] cx_ff;
   logic signed [35:0] cy_ff;
   logic signed [24:0] cz_ff;

   logic signed [16:0] ang;
   logic               in_range;
   logic               take_pt;
   logic               fold;
   logic signed [16:0] fold_ang;
   logic [31:0]        x_init;
   logic signed [35:0] sx;
   logic signed [35:0] sy;
   logic signed [24:0] at;
   logic signed [35:0] rx;
   logic signed [35:0] ry;
   logic               accept;

   assign req.ready = (state_ff == F_IDLE);
   assign accept    = req.valid && req.ready;

   // next beam angle and range check
   always_comb begin
      if (scan_active_ff)
         ang = 17'(signed'(beam_ff)) + 17'(signed'(cfg.angle_step));
      else
         ang = 17'(signed'(cfg.angle_start));
      in_range = !(ang > 17'sd32767 || ang < -17'sd32768 ||
                   ang > 17'(signed'(cfg.angle_end)));
      take_pt  = !past_end_ff && in_range;
      fold     = (ang > 17'sd16384) || (ang < -17'sd16384);
      if (ang > 17'sd16384)
         fold_ang = ang - 17'sd32768;
      else if (ang < -17'sd16384)
         fold_ang = ang + 17'sd32768;
      else
         fold_ang = ang;
      x_init = 32'(req.range_mm) * 32'(KINV_Q16);
   end

   // one rotation step
   always_comb begin
      sx = cy_ff >>> iter_ff;
      sy = cx_ff >>> iter_ff;
      at = atan_val(iter_ff);
   end

   // round to whole mm and undo the fold
   always_comb begin
      rx = (cx_ff + 36'sd32768) >>> 16;
      ry = (cy_ff + 36'sd32768) >>> 16;
      if (flip_ff) begin
         rx = -rx;
         ry = -ry;
      end
      push_entry.pt  = pt_ff;
      push_entry.eos = eos_ff;
      push_entry.x   = pt_ff ? clamp_pos(40'(rx)) : '0;
      push_entry.y   = pt_ff ? clamp_pos(40'(ry)) : '0;
   end

   assign push_valid = (state_ff == F_PUSH);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= F_IDLE;
         scan_active_ff <= 1'b0;
         past_end_ff    <= 1'b0;
         beam_ff        <= '0;
         pt_ff          <= 1'b0;
         eos_ff         <= 1'b0;
         iter_ff        <= '0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  pt_ff   <= take_pt;
                  eos_ff  <= req.end_of_scan;
                  iter_ff <= '0;
                  flip_ff <= fold;
                  cx_ff   <= 36'(x_init);
                  cy_ff   <= '0;
                  cz_ff   <= {fold_ang, 8'b0};
                  if (take_pt)
                     beam_ff <= ang[15:0];
                  // close out the scan, else track it
                  if (req.end_of_scan) begin
                     scan_active_ff <= 1'b0;
                     past_end_ff    <= 1'b0;
                  end else if (!past_end_ff) begin
                     scan_active_ff <= 1'b1;
                     if (!in_range)
                        past_end_ff <= 1'b1;
                  end
                  if (take_pt)
                     state_ff <= F_ROT;
                  else if (req.end_of_scan)
                     state_ff <= F_PUSH;
               end
            end
            F_ROT: begin
               if (cz_ff >= 0) begin
                  cx_ff <= cx_ff - sx;
                  cy_ff <= cy_ff + sy;
                  cz_ff <= cz_ff - at;
               end else begin
                  cx_ff <= cx_ff + sx;
                  cy_ff <= cy_ff - sy;
                  cz_ff <= cz_ff + at;
               end
               iter_ff <= iter_ff + 5'd1;
               if (iter_ff == 5'(STEPS - 1))
                  state_ff <= F_PUSH;
            end
            F_PUSH: begin
               if (push_ready)
                  state_ff <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

### rtl/core/llcd_fifo.sv
// Two-entry queue of converted points between the front and back ends.
// Depends on llcd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module llcd_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire llcd_pkg::pt_entry_type in_entry,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   output llcd_pkg::pt_entry_type     out_entry,
   output logic                       out_valid,
   input  wire logic                  out_ready
);
   import llcd_pkg::*;

   pt_entry_type mem_ff [2];
   logic         wr_ptr_ff;
   logic         rd_ptr_ff;
   logic [1:0]   count_ff;
   logic         do_push;
   logic         do_pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_entry = mem_ff[rd_ptr_ff];
   assign do_push   = in_valid && in_ready;
   assign do_pop    = out_valid && out_ready;

   // store the beat
   always_ff @(posedge clock) begin
      if (do_push)
         mem_ff[wr_ptr_ff] <= in_entry;
   end

   // advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (do_push)
            wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)
            rd_ptr_ff <= !rd_ptr_ff;
         if (do_push && !do_pop)
            count_ff <= count_ff + 2'd1;
         else if (do_pop && !do_push)
            count_ff <= count_ff - 2'd1;
      end
   end

endmodule
`default_nettype wire

### rtl/core/llcd_back.sv
// Back end: clustering, path length by iterative square root, leg test,
// centroid by iterative division, target choice and report output register.
// Depends on llcd_pkg and llcd_if.
`timescale 1ns / 1ps
`default_nettype none
module llcd_back #(
   parameter int MAX_POINTS = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire llcd_pkg::cfg_type     cfg,
   input  wire llcd_pkg::pt_entry_type pop_entry,
   input  wire logic                  pop_valid,
   output logic                       pop_ready,
   llcd_rsp_if.source                 rsp
);
   import llcd_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS) + 1;
   localparam int SUM_W = 17 + CNT_W;
   localparam int DCW   = $clog2(SUM_W + 1);

   typedef enum logic [4:0] {
      B_IDLE, B_PT_CHK, B_PT_RAD, B_SPLIT, B_SQRT, B_PATH, B_START, B_AFTER,
      B_EOS, B_CLOSE, B_CURVE_A, B_CURVE_B, B_CURVE_C, B_CURVE_D, B_CURVE_E,
      B_DIV_INIT, B_DIV_RUN, B_DIV_DONE, B_LEG_EMIT, B_BEST_A, B_BEST_B,
      B_REPORT, B_D2_X, B_D2_Y, B_D2_S
   } bstate_type;

   bstate_type               state_ff;
   bstate_type               ret_ff;
   bstate_type               close_ret_ff;

   // current beat
   logic signed [16:0]       cur_x_ff;
   logic signed [16:0]       cur_y_ff;
   logic                     cur_eos_ff;

   // cluster state
   logic signed [16:0]       first_x_ff;
   logic signed [16:0]       first_y_ff;
   logic signed [16:0]       prev_x_ff;
   logic signed [16:0]       prev_y_ff;
   logic [23:0]              path_ff;
   logic signed [SUM_W-1:0]  sum_x_ff;
   logic signed [SUM_W-1:0]  sum_y_ff;
   logic [CNT_W-1:0]         count_ff;
   logic                     best_valid_ff;
   logic signed [16:0]       best_x_ff;
   logic signed [16:0]       best_y_ff;
   logic [35:0]              best_d2_ff;
   logic signed [16:0]       target_x_ff;
   logic signed [16:0]       target_y_ff;

   // arithmetic scratch
   logic [16:0]              dx_ff;
   logic [16:0]              dy_ff;
   logic [63:0]              acc_ff;
   logic [35:0]              d2_ff;
   logic [35:0]              rad2_ff;
   logic [47:0]              lhs_ff;
   logic [31:0]              mc2_ff;
   logic [63:0]              prod_ff;
   logic [31:0]              mul_a_in;
   logic [31:0]              mul_b_in;

   logic [35:0]              sq_n_ff;
   logic [20:0]              sq_rem_ff;
   logic [17:0]              sq_root_ff;
   logic [4:0]               sq_cnt_ff;
   logic [20:0]              sq_sh;
   logic [20:0]              sq_trial;

   logic [SUM_W-1:0]         dv_num_ff;
   logic [CNT_W-1:0]         dv_rem_ff;
   logic [DCW-1:0]           dv_cnt_ff;
   logic                     dv_sel_ff;
   logic                     dv_neg_ff;
   logic [CNT_W:0]           dv_sh;
   logic                     dv_ge;
   logic signed [SUM_W-1:0]  dv_sum;
   logic [SUM_W-1:0]         dv_mag;
   logic signed [SUM_W:0]    dv_val;
   logic signed [16:0]       cen_x_ff;
   logic signed [16:0]       cen_y_ff;

   // output register
   logic                     rsp_valid_ff;
   logic                     rsp_kind_ff;
   logic signed [16:0]       rsp_x_ff;
   logic signed [16:0]       rsp_y_ff;
   logic                     rsp_upd_ff;
   logic                     rsp_last_ff;
   logic                     out_free;
   logic                     rsp_load;

   logic signed [17:0]       diff_a;
   logic signed [17:0]       diff_b;
   logic [24:0]              path_sum;
   logic [67:0]              curve_rhs;
   logic                     leg_len_ok;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign rsp_load  = out_free && (state_ff == B_LEG_EMIT || state_ff == B_REPORT);
   assign pop_ready = (state_ff == B_IDLE);

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.report_kind    = rsp_kind_ff;
   assign rsp.pos_x_mm       = rsp_x_ff;
   assign rsp.pos_y_mm       = rsp_y_ff;
   assign rsp.target_updated = rsp_upd_ff;
   assign rsp.last_of_run    = rsp_last_ff;

   // shared multiplier operands
   always_comb begin
      mul_a_in = '0;
      mul_b_in = '0;
      unique case (state_ff)
         B_D2_X: begin
            mul_a_in = 32'(dx_ff);
            mul_b_in = 32'(dx_ff);
         end
         B_D2_Y: begin
            mul_a_in = 32'(dy_ff);
            mul_b_in = 32'(dy_ff);
         end
         B_PT_CHK: begin
            mul_a_in = 32'(cfg.cluster_radius_mm);
            mul_b_in = 32'(cfg.cluster_radius_mm);
         end
         B_CURVE_A: begin
            mul_a_in = {8'b0, path_ff[15:0], 8'b0};
            mul_b_in = {8'b0, path_ff[15:0], 8'b0};
         end
         B_CURVE_B: begin
            mul_a_in = 32'(cfg.min_curve_q8);
            mul_b_in = 32'(cfg.min_curve_q8);
         end
         B_CURVE_C: begin
            mul_a_in = d2_ff[31:0];
            mul_b_in = prod_ff[31:0];
         end
         B_CURVE_D: begin
            mul_a_in = {28'b0, d2_ff[35:32]};
            mul_b_in = mc2_ff;
         end
         B_BEST_A: begin
            mul_a_in = 32'(cfg.max_target_mm);
            mul_b_in = 32'(cfg.max_target_mm);
         end
         default: begin
            mul_a_in = '0;
            mul_b_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a_in) * 64'(mul_b_in);
   end

   // square root and divider steps, misc datapath
   always_comb begin
      sq_sh      = {sq_rem_ff[18:0], sq_n_ff[35:34]};
      sq_trial   = {1'b0, sq_root_ff, 2'b01};
      dv_sh      = {dv_rem_ff, dv_num_ff[SUM_W-1]};
      dv_ge      = dv_sh >= {1'b0, count_ff};
      dv_sum     = dv_sel_ff ? sum_y_ff : sum_x_ff;
      dv_mag     = dv_sum[SUM_W-1] ? SUM_W'(-dv_sum) : SUM_W'(dv_sum);
      dv_val     = dv_neg_ff ? -signed'({1'b0, dv_num_ff}) : signed'({1'b0, dv_num_ff});
      path_sum   = {1'b0, path_ff} + 25'(sq_root_ff);
      curve_rhs  = {4'b0, acc_ff} + {prod_ff[35:0], 32'b0};
      leg_len_ok = (path_ff > 24'(cfg.leg_len_min_mm)) &&
                   (path_ff < 24'(cfg.leg_len_max_mm));
      diff_a     = 18'(cur_x_ff) - 18'(first_x_ff);
      diff_b     = 18'(cur_y_ff) - 18'(first_y_ff);
   end

   function automatic logic [16:0] abs18(input logic signed [17:0] v);
      return v[17] ? 17'(-v) : v[16:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         ret_ff        <= B_IDLE;
         close_ret_ff  <= B_IDLE;
         count_ff      <= '0;
         path_ff       <= '0;
         best_valid_ff <= 1'b0;
         target_x_ff   <= '0;
         target_y_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // drop a taken report unless a new one loads
         if (rsp_valid_ff && rsp.ready && !rsp_load)
            rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            B_IDLE: begin
               if (pop_valid) begin
                  cur_x_ff   <= pop_entry.x;
                  cur_y_ff   <= pop_entry.y;
                  cur_eos_ff <= pop_entry.eos;
                  state_ff   <= pop_entry.pt ? B_PT_CHK : B_EOS;
               end
            end
            B_PT_CHK: begin
               if (count_ff == '0)
                  state_ff <= B_START;
               else
                  state_ff <= B_PT_RAD;
            end
            B_PT_RAD: begin
               rad2_ff  <= 36'(prod_ff[31:0]);
               dx_ff    <= abs18(diff_a);
               dy_ff    <= abs18(diff_b);
               ret_ff   <= B_SPLIT;
               state_ff <= B_D2_X;
            end
            B_SPLIT: begin
               if (d2_ff > rad2_ff || count_ff >= CNT_W'(MAX_POINTS)) begin
                  close_ret_ff <= B_START;
                  state_ff     <= B_CLOSE;
               end else begin
                  dx_ff    <= abs18(18'(cur_x_ff) - 18'(prev_x_ff));
                  dy_ff    <= abs18(18'(cur_y_ff) - 18'(prev_y_ff));
                  ret_ff   <= B_SQRT;
                  // first pass through B_SQRT loads the root unit
                  sq_cnt_ff <= 5'd31;
                  state_ff <= B_D2_X;
               end
            end
            B_SQRT: begin
               if (sq_cnt_ff == 5'd31) begin
                  sq_n_ff    <= d2_ff;
                  sq_rem_ff  <= '0;
                  sq_root_ff <= '0;
                  sq_cnt_ff  <= '0;
               end else begin
                  sq_n_ff <= {sq_n_ff[33:0], 2'b00};
                  if (sq_sh >= sq_trial) begin
                     sq_rem_ff  <= sq_sh - sq_trial;
                     sq_root_ff <= {sq_root_ff[16:0], 1'b1};
                  end else begin
                     sq_rem_ff  <= sq_sh;
                     sq_root_ff <= {sq_root_ff[16:0], 1'b0};
                  end
                  sq_cnt_ff <= sq_cnt_ff + 5'd1;
                  if (sq_cnt_ff == 5'd17)
                     state_ff <= B_PATH;
               end
            end
            B_PATH: begin
               path_ff   <= path_sum[24] ? 24'hFFFFFF : path_sum[23:0];
               sum_x_ff  <= sum_x_ff + SUM_W'(cur_x_ff);
               sum_y_ff  <= sum_y_ff + SUM_W'(cur_y_ff);
               count_ff  <= count_ff + CNT_W'(1);
               prev_x_ff <= cur_x_ff;
               prev_y_ff <= cur_y_ff;
               state_ff  <= B_AFTER;
            end
            B_START: begin
               first_x_ff <= cur_x_ff;
               first_y_ff <= cur_y_ff;
               prev_x_ff  <= cur_x_ff;
               prev_y_ff  <= cur_y_ff;
               path_ff    <= '0;
               sum_x_ff   <= SUM_W'(cur_x_ff);
               sum_y_ff   <= SUM_W'(cur_y_ff);
               count_ff   <= CNT_W'(1);
               state_ff   <= B_AFTER;
            end
            B_AFTER: begin
               state_ff <= cur_eos_ff ? B_EOS : B_IDLE;
            end
            B_EOS: begin
               close_ret_ff <= B_REPORT;
               state_ff     <= B_CLOSE;
            end
            // close the open cluster, test for a leg
            B_CLOSE: begin
               if (count_ff == '0) begin
                  state_ff <= close_ret_ff;
               end else if (!leg_len_ok) begin
                  count_ff <= '0;
                  state_ff <= close_ret_ff;
               end else begin
                  dx_ff    <= abs18(18'(prev_x_ff) - 18'(first_x_ff));
                  dy_ff    <= abs18(18'(prev_y_ff) - 18'(first_y_ff));
                  ret_ff   <= B_CURVE_A;
                  state_ff <= B_D2_X;
               end
            end
            B_CURVE_A: state_ff <= B_CURVE_B;
            B_CURVE_B: begin
               lhs_ff   <= prod_ff[47:0];
               state_ff <= B_CURVE_C;
            end
            B_CURVE_C: begin
               mc2_ff   <= prod_ff[31:0];
               state_ff <= B_CURVE_D;
            end
            B_CURVE_D: begin
               acc_ff   <= prod_ff;
               state_ff <= B_CURVE_E;
            end
            B_CURVE_E: begin
               if (lhs_ff != '0 && (mc2_ff == '0 || curve_rhs < 68'(lhs_ff))) begin
                  dv_sel_ff <= 1'b0;
                  state_ff  <= B_DIV_INIT;
               end else begin
                  count_ff <= '0;
                  state_ff <= close_ret_ff;
               end
            end
            // centroid, x then y
            B_DIV_INIT: begin
               dv_neg_ff <= dv_sum[SUM_W-1];
               dv_num_ff <= dv_mag + SUM_W'(count_ff >> 1);
               dv_rem_ff <= '0;
               dv_cnt_ff <= '0;
               state_ff  <= B_DIV_RUN;
            end
            B_DIV_RUN: begin
               dv_num_ff <= {dv_num_ff[SUM_W-2:0], dv_ge};
               dv_rem_ff <= dv_ge ? CNT_W'(dv_sh - {1'b0, count_ff}) : CNT_W'(dv_sh);
               dv_cnt_ff <= dv_cnt_ff + DCW'(1);
               if (dv_cnt_ff == DCW'(SUM_W - 1))
                  state_ff <= B_DIV_DONE;
            end
            B_DIV_DONE: begin
               if (dv_sel_ff) begin
                  cen_y_ff <= clamp_pos(40'(dv_val));
                  state_ff <= B_LEG_EMIT;
               end else begin
                  cen_x_ff  <= clamp_pos(40'(dv_val));
                  dv_sel_ff <= 1'b1;
                  state_ff  <= B_DIV_INIT;
               end
            end
            B_LEG_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= KIND_LEG;
                  rsp_x_ff     <= cen_x_ff;
                  rsp_y_ff     <= cen_y_ff;
                  rsp_upd_ff   <= 1'b0;
                  // an end-of-scan beat always ends with its target report
                  rsp_last_ff  <= !cur_eos_ff;
                  dx_ff        <= abs18(18'(cen_x_ff));
                  dy_ff        <= abs18(18'(cen_y_ff));
                  ret_ff       <= B_BEST_A;
                  state_ff     <= B_D2_X;
               end
            end
            B_BEST_A: state_ff <= B_BEST_B;
            B_BEST_B: begin
               if (36'(prod_ff[31:0]) > d2_ff &&
                   (!best_valid_ff || d2_ff > best_d2_ff)) begin
                  best_valid_ff <= 1'b1;
                  best_x_ff     <= cen_x_ff;
                  best_y_ff     <= cen_y_ff;
                  best_d2_ff    <= d2_ff;
               end
               count_ff <= '0;
               state_ff <= close_ret_ff;
            end
            B_REPORT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= KIND_TARGET;
                  rsp_upd_ff   <= best_valid_ff;
                  rsp_last_ff  <= 1'b1;
                  if (best_valid_ff) begin
                     target_x_ff <= best_x_ff;
                     target_y_ff <= best_y_ff;
                     rsp_x_ff    <= best_x_ff;
                     rsp_y_ff    <= best_y_ff;
                  end else begin
                     rsp_x_ff <= target_x_ff;
                     rsp_y_ff <= target_y_ff;
                  end
                  best_valid_ff <= 1'b0;
                  count_ff      <= '0;
                  state_ff      <= B_IDLE;
               end
            end
            // squared distance of dx_ff, dy_ff
            B_D2_X: state_ff <= B_D2_Y;
            B_D2_Y: begin
               acc_ff   <= prod_ff;
               state_ff <= B_D2_S;
            end
            B_D2_S: begin
               d2_ff    <= 36'(acc_ff[34:0]) + 36'(prod_ff[34:0]);
               state_ff <= ret_ff;
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

### rtl/core/lidar_leg_cluster_detector.sv
// A sample passes the front end (accept, CORDIC_STEPS shift-add steps, hand-off), then the
// back end, which, when it extends a cluster, works out the radius square and two squared
// distances on one multiplier and an 18-step square root. Closing a leg runs two centroid
// divisions; an end of scan adds the report. The two-entry queue lets the halves overlap,
// though each half takes a new sample only when done with the last. Synchronous
// active-high reset restores defaults.
`timescale 1ns / 1ps
`default_nettype none
module lidar_leg_cluster_detector #(
   parameter int MAX_POINTS   = 1024,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   llcd_req_if.sink         req,
   llcd_rsp_if.source       rsp,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import llcd_pkg::*;

   cfg_type      cfg_ff;
   pt_entry_type push_entry;
   logic         push_valid;
   logic         push_ready;
   pt_entry_type pop_entry;
   logic         pop_valid;
   logic         pop_ready;
   logic [2:0]   reg_idx;
   logic [15:0]  rd_val;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cluster_radius_mm <= RST_CLUSTER_RADIUS;
         cfg_ff.min_curve_q8      <= RST_MIN_CURVE;
         cfg_ff.leg_len_min_mm    <= RST_LEG_LEN_MIN;
         cfg_ff.leg_len_max_mm    <= RST_LEG_LEN_MAX;
         cfg_ff.max_target_mm     <= RST_MAX_TARGET;
         cfg_ff.angle_start       <= RST_ANGLE_START;
         cfg_ff.angle_step        <= RST_ANGLE_STEP;
         cfg_ff.angle_end         <= RST_ANGLE_END;
      end else if (psel && penable && pwrite) begin
         unique case (reg_idx)
            REG_CLUSTER_RADIUS: cfg_ff.cluster_radius_mm <= pwdata[15:0];
            REG_MIN_CURVE:      cfg_ff.min_curve_q8      <= pwdata[15:0];
            REG_LEG_LEN_MIN:    cfg_ff.leg_len_min_mm    <= pwdata[15:0];
            REG_LEG_LEN_MAX:    cfg_ff.leg_len_max_mm    <= pwdata[15:0];
            REG_MAX_TARGET:     cfg_ff.max_target_mm     <= pwdata[15:0];
            REG_ANGLE_START:    cfg_ff.angle_start       <= pwdata[15:0];
            REG_ANGLE_STEP:     cfg_ff.angle_step        <= pwdata[15:0];
            REG_ANGLE_END:      cfg_ff.angle_end         <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (reg_idx)
         REG_CLUSTER_RADIUS: rd_val = cfg_ff.cluster_radius_mm;
         REG_MIN_CURVE:      rd_val = cfg_ff.min_curve_q8;
         REG_LEG_LEN_MIN:    rd_val = cfg_ff.leg_len_min_mm;
         REG_LEG_LEN_MAX:    rd_val = cfg_ff.leg_len_max_mm;
         REG_MAX_TARGET:     rd_val = cfg_ff.max_target_mm;
         REG_ANGLE_START:    rd_val = cfg_ff.angle_start;
         REG_ANGLE_STEP:     rd_val = cfg_ff.angle_step;
         REG_ANGLE_END:      rd_val = cfg_ff.angle_end;
         default:            rd_val = '0;
      endcase
      prdata = 32'(rd_val);
   end

   llcd_front #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .cfg        (cfg_ff),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   llcd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_entry  (push_entry),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .out_entry (pop_entry),
      .out_valid (pop_valid),
      .out_ready (pop_ready)
   );

   llcd_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_entry (pop_entry),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp       (rsp)
   );

endmodule
`default_nettype wire

### bench/llcd_checker.sv
// Checker for the lidar leg cluster detector: watches the sample, report and register buses,
// predicts the reports and compares them. Depends on llcd_pkg and the channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
module llcd_checker
   import llcd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   llcd_req_if              req,
   llcd_rsp_if              rsp,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic        pready,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output int               errors,
   output int               pending,
   output int               legs_seen,
   output int               targets_seen,
   output int               targets_loaded
);

   localparam int  CLUSTER_CAP = 1024;
   localparam int  ROT_STEPS   = 16;
   localparam longint PATH_MAX = 64'hFF_FFFF;

   typedef struct {
      logic               kind;
      logic signed [16:0] x;
      logic signed [16:0] y;
      logic               upd;
      logic               last;
   } report_type;

   report_type expected_reports[$];
   longint     atan_q8 [0:23];

   cfg_type            cfg;
   logic signed [15:0] beam_angle;
   longint             first_x, first_y, prev_x, prev_y, path_len, sum_x, sum_y;
   int                 n_points;
   bit                 best_ok, scan_open, beyond_end;
   longint             best_x, best_y, tgt_x, tgt_y;

   initial begin
      errors = 0;
      legs_seen = 0;
      targets_seen = 0;
      targets_loaded = 0;
      atan_q8 = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
                  10430, 5215, 2608, 1304, 652, 326, 163, 81,
                  41, 20, 10, 5, 3, 1, 1, 0};
   end

   function automatic longint sat_pos(input longint v);
      if (v < -65536) return -65536;
      if (v > 65535) return 65535;
      return v;
   endfunction

   function automatic longint sq_dist(input longint ax, ay, bx, by);
      return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
   endfunction

   function automatic longint floor_sqrt(input longint n);
      longint r;
      r = longint'($floor($sqrt(real'(n))));
      while (r * r > n) r--;
      while ((r + 1) * (r + 1) <= n) r++;
      return r;
   endfunction

   function automatic longint div_round(input longint s, input longint c);
      if (s >= 0) return (s + c / 2) / c;
      return -((-s + c / 2) / c);
   endfunction

   // rotate (range, 0) to the beam angle; fold by pi and negate for the rear half
   task automatic beam_to_xy(input longint r, input longint ang, output longint ox, oy);
      bit     flip;
      longint x, y, z, dx, dy;
      flip = 0;
      if (ang > 16384 || ang < -16384) begin
         ang = (ang > 0) ? ang - 32768 : ang + 32768;
         flip = 1;
      end
      x = r * 39797;
      y = 0;
      z = ang * 256;
      for (int i = 0; i < ROT_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_q8[i];
         end else begin
            x += dx; y -= dy; z += atan_q8[i];
         end
      end
      x = (x + 32768) >>> 16;
      y = (y + 32768) >>> 16;
      if (flip) begin
         x = -x; y = -y;
      end
      ox = sat_pos(x);
      oy = sat_pos(y);
   endtask

   task automatic expect_report(input logic k, input longint x, y, input logic u);
      report_type t;
      t.kind = k;
      t.x = x[16:0];
      t.y = y[16:0];
      t.upd = u;
      t.last = 1'b0;
      expected_reports.insert(expected_reports.size(), t);
   endtask

   // close the open cluster; a leg emits its centroid and may become the scan's best
   task automatic close_cluster();
      longint len, d2, lhs, mc2, cx, cy;
      bit     leg;
      if (n_points == 0) return;
      len = path_len;
      leg = len > cfg.leg_len_min_mm && len < cfg.leg_len_max_mm;
      if (leg) begin
         d2  = sq_dist(prev_x, prev_y, first_x, first_y);
         lhs = (len * 256) * (len * 256);
         mc2 = longint'(cfg.min_curve_q8) * longint'(cfg.min_curve_q8);
         if (mc2 == 0) leg = lhs > 0;
         else leg = lhs > 0 && d2 <= (lhs - 1) / mc2;
      end
      if (leg) begin
         cx = sat_pos(div_round(sum_x, n_points));
         cy = sat_pos(div_round(sum_y, n_points));
         expect_report(KIND_LEG, cx, cy, 1'b0);
         d2 = cx * cx + cy * cy;
         if (d2 < longint'(cfg.max_target_mm) * longint'(cfg.max_target_mm) &&
             (!best_ok || d2 > best_x * best_x + best_y * best_y)) begin
            best_ok = 1;
            best_x = cx;
            best_y = cy;
         end
      end
      n_points = 0;
   endtask

   task automatic open_cluster(input longint x, y);
      first_x = x; prev_x = x; first_y = y; prev_y = y;
      path_len = 0;
      sum_x = x; sum_y = y;
      n_points = 1;
   endtask

   task automatic add_point(input longint x, y);
      longint rad;
      rad = cfg.cluster_radius_mm;
      if (n_points == 0) begin
         open_cluster(x, y);
      end else if (sq_dist(x, y, first_x, first_y) > rad * rad || n_points >= CLUSTER_CAP) begin
         close_cluster();
         open_cluster(x, y);
      end else begin
         path_len += floor_sqrt(sq_dist(x, y, prev_x, prev_y));
         if (path_len > PATH_MAX) path_len = PATH_MAX;
         sum_x += x; sum_y += y;
         n_points++;
         prev_x = x; prev_y = y;
      end
   endtask

   // work out every report that one accepted sample causes
   task automatic predict_sample(input logic [15:0] r, input logic eos);
      longint a, x, y;
      int     n0;
      logic   upd;
      n0 = expected_reports.size();
      upd = 1'b0;
      if (!beyond_end) begin
         if (!scan_open) begin
            a = longint'($signed(cfg.angle_start));
            scan_open = 1;
         end else begin
            a = longint'(beam_angle) + longint'($signed(cfg.angle_step));
         end
         if (a < -32768 || a > 32767 || a > longint'($signed(cfg.angle_end))) begin
            beyond_end = 1;
         end else begin
            beam_angle = a[15:0];
            beam_to_xy(longint'(r), a, x, y);
            add_point(x, y);
         end
      end
      if (eos) begin
         close_cluster();
         if (best_ok) begin
            tgt_x = best_x; tgt_y = best_y;
            upd = 1'b1;
         end
         expect_report(KIND_TARGET, tgt_x, tgt_y, upd);
         best_ok = 0; scan_open = 0; beyond_end = 0; n_points = 0;
      end
      if (expected_reports.size() > n0)
         expected_reports[$].last = 1'b1;
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: report %s is %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   task automatic check_report();
      report_type t;
      if (expected_reports.size() == 0) begin
         report_mismatch("beat with nothing pending, kind", rsp.report_kind, -1);
         return;
      end
      t = expected_reports.pop_front();
      if (rsp.report_kind !== t.kind) report_mismatch("kind", rsp.report_kind, t.kind);
      if (rsp.pos_x_mm !== t.x) report_mismatch("x", rsp.pos_x_mm, t.x);
      if (rsp.pos_y_mm !== t.y) report_mismatch("y", rsp.pos_y_mm, t.y);
      if (rsp.target_updated !== t.upd) report_mismatch("updated", rsp.target_updated, t.upd);
      if (rsp.last_of_run !== t.last) report_mismatch("last", rsp.last_of_run, t.last);
      if (t.kind == KIND_LEG) legs_seen++;
      else targets_seen++;
      if (t.kind == KIND_TARGET && t.upd) targets_loaded++;
   endtask

   // track register writes, then reports, then samples at each edge
   always @(posedge clock) begin
      if (reset) begin
         cfg.cluster_radius_mm = RST_CLUSTER_RADIUS;
         cfg.min_curve_q8      = RST_MIN_CURVE;
         cfg.leg_len_min_mm    = RST_LEG_LEN_MIN;
         cfg.leg_len_max_mm    = RST_LEG_LEN_MAX;
         cfg.max_target_mm     = RST_MAX_TARGET;
         cfg.angle_start       = RST_ANGLE_START;
         cfg.angle_step        = RST_ANGLE_STEP;
         cfg.angle_end         = RST_ANGLE_END;
         beam_angle = 0;
         first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
         path_len = 0; sum_x = 0; sum_y = 0; n_points = 0;
         best_ok = 0; best_x = 0; best_y = 0; tgt_x = 0; tgt_y = 0;
         scan_open = 0; beyond_end = 0;
         expected_reports.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_CLUSTER_RADIUS: cfg.cluster_radius_mm = pwdata[15:0];
               REG_MIN_CURVE:      cfg.min_curve_q8      = pwdata[15:0];
               REG_LEG_LEN_MIN:    cfg.leg_len_min_mm    = pwdata[15:0];
               REG_LEG_LEN_MAX:    cfg.leg_len_max_mm    = pwdata[15:0];
               REG_MAX_TARGET:     cfg.max_target_mm     = pwdata[15:0];
               REG_ANGLE_START:    cfg.angle_start       = pwdata[15:0];
               REG_ANGLE_STEP:     cfg.angle_step        = pwdata[15:0];
               REG_ANGLE_END:      cfg.angle_end         = pwdata[15:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) check_report();
         if (req.valid && req.ready) predict_sample(req.range_mm, req.end_of_scan);
      end
      pending <= expected_reports.size();
   end

endmodule
`default_nettype wire

### bench/lidar_leg_cluster_detector_test.sv
// Top of the lidar leg cluster detector bench: clock, reset, sample scans, register phases
// and the verdict. Depends on llcd_pkg, the channel interfaces, the block and llcd_checker.
`timescale 1ns / 1ps
`default_nettype none
module lidar_leg_cluster_detector_test;
   import llcd_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE      = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   int errors, pending, legs_seen, targets_seen, targets_loaded;
   int cycles = 0;
   int samples_sent = 0;
   int snd_idle = 38, rcv_idle = 55;
   int hold_asked = 0, hold_done = 0, hold_left = 0;

   llcd_req_if req ();
   llcd_rsp_if rsp ();

   initial begin
      req.valid = 1'b0;
      req.range_mm = '0;
      req.end_of_scan = 1'b0;
      rsp.ready = 1'b0;
   end

   lidar_leg_cluster_detector u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   llcd_checker u_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending),
      .legs_seen(legs_seen), .targets_seen(targets_seen), .targets_loaded(targets_loaded)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // end the run if it stalls
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports pending", cycles, pending);
         $display("lidar_leg_cluster_detector: mismatch");
         $finish;
      end
   end

   // report receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_asked != hold_done) begin
         hold_done <= hold_asked;
         hold_left <= 700;
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   // one register write: setup beat, access beat, then release
   task automatic csr_write(input logic [2:0] idx, input logic [15:0] v);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= {16'h0, v};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_config(input logic [15:0] rad, curve, lmin, lmax, tmax,
                              input logic [15:0] a0, da, a1);
      csr_write(REG_CLUSTER_RADIUS, rad);
      csr_write(REG_MIN_CURVE, curve);
      csr_write(REG_LEG_LEN_MIN, lmin);
      csr_write(REG_LEG_LEN_MAX, lmax);
      csr_write(REG_MAX_TARGET, tmax);
      csr_write(REG_ANGLE_START, a0);
      csr_write(REG_ANGLE_STEP, da);
      csr_write(REG_ANGLE_END, a1);
   endtask

   // drain all reports, then let a closing division finish
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // offer one sample beat and hold it until accepted; ready is stable at the falling edge
   task automatic push_sample(input logic [15:0] r, input logic eos);
      while ($urandom_range(99) < snd_idle) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.range_mm <= r;
      req.end_of_scan <= eos;
      @(negedge clock);
      while (!req.ready) begin
         @(posedge clock);
         @(negedge clock);
      end
      @(posedge clock);
      samples_sent++;
   endtask

   // one scan: background wall with one leg-shaped bump, sometimes noise or no end mark
   task automatic push_scan();
      int  len, leg_at, leg_w, leg_r, bump, wall;
      int  r;
      bit  noisy, no_end;
      real s;
      len    = $urandom_range(12, 70);
      noisy  = ($urandom_range(99) < 15);
      no_end = ($urandom_range(99) < 8);
      wall   = $urandom_range(1500, 9000);
      leg_at = $urandom_range(0, len / 2);
      leg_w  = $urandom_range(6, 30);
      leg_r  = $urandom_range(250, 6000);
      bump   = $urandom_range(10, 120);
      for (int k = 0; k < len; k++) begin
         if (noisy) begin
            r = $urandom_range(0, 65535);
         end else if (k >= leg_at && k < leg_at + leg_w) begin
            s = $sin(3.14159265 * (k - leg_at) / (leg_w - 1));
            r = leg_r - int'(bump * s) + $urandom_range(0, 3);
         end else begin
            r = wall + $urandom_range(0, 40);
         end
         push_sample(r[15:0], (k == len - 1) && !no_end);
      end
   endtask

   task automatic push_scans_until(input int goal);
      while (samples_sent < goal) push_scan();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed beats at reset settings: range extremes, short scans, one clean leg
      push_sample(16'd0, 1'b0);
      push_sample(16'hFFFF, 1'b0);
      push_sample(16'hFFFF, 1'b1);
      push_sample(16'd100, 1'b1);
      push_sample(16'd3000, 1'b0);
      for (int k = 0; k < 14; k++)
         push_sample(16'(1000 - int'(50.0 * $sin(3.14159265 * k / 13.0))), 1'b0);
      push_sample(16'd3000, 1'b0);
      push_sample(16'd3000, 1'b1);
      drain();

      // sender idles 38, receiver 55; reset settings then generous limits
      snd_idle = 38; rcv_idle = 55;
      push_scans_until(150);
      drain();
      load_config(16'd65535, 16'd0, 16'd0, 16'd65535, 16'd65535,
                  16'h8000, 16'd64, 16'h7FFF);
      push_scans_until(260);
      drain();

      // tight limits, radius zero
      load_config(16'd0, 16'd65535, 16'd65535, 16'd0, 16'd0,
                  16'hC000, 16'd200, 16'h0000);
      push_scans_until(320);
      drain();

      // swap idle rates; angle sum leaves the signed range, negative step
      snd_idle = 55; rcv_idle = 38;
      load_config(16'd500, 16'd282, 16'd60, 16'd200, 16'd5000,
                  16'h7F00, 16'd32767, 16'h7FFF);
      push_scans_until(370);
      drain();
      load_config(16'd400, 16'd300, 16'd40, 16'd250, 16'd8000,
                  16'h4000, 16'h8000, 16'h7FFF);
      push_scans_until(420);
      drain();
      load_config(16'd600, 16'd270, 16'd50, 16'd300, 16'd7000,
                  16'h7000, 16'hFFC0, 16'h7FFF);
      push_scans_until(520);
      drain();

      // no idling; long receiver hold-off while samples keep coming
      snd_idle = 0; rcv_idle = 0;
      load_config(16'd500, 16'd282, 16'd60, 16'd200, 16'd6000,
                  16'hA000, 16'd48, 16'h6000);
      hold_asked = hold_asked + 1;
      push_scans_until(820);
      drain();

      load_config(16'(500 + $urandom_range(0, 300)), 16'd282, 16'd60, 16'd220, 16'd5000,
                  16'h8000, 16'd64, 16'h7FFF);
      push_scans_until(1120);
      drain();

      $display("%0d samples sent over eight register settings", samples_sent);
      $display("%0d leg reports and %0d scan reports (%0d with a new target) checked",
               legs_seen, targets_seen, targets_loaded);
      if (errors == 0) begin
         $display("lidar_leg_cluster_detector: match");
      end else begin
         $display("lidar_leg_cluster_detector: mismatch");
      end
      $finish;
   end

endmodule
`default_nettype wire

### filelist.f
rtl/core/llcd_pkg.sv
rtl/core/llcd_if.sv
rtl/core/llcd_front.sv
rtl/core/llcd_fifo.sv
rtl/core/llcd_back.sv
rtl/core/lidar_leg_cluster_detector.sv
bench/llcd_checker.sv
bench/lidar_leg_cluster_detector_test.sv
